FILE: rtl/pia_kdp_pkg.sv
package pia_kdp_pkg;

  // input transaction kinds
  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_IDLE  = 2'd3
  } kind_e;

  // result transaction kinds
  typedef enum logic [0:0] {
    RES_READ    = 1'b0,
    RES_DISPLAY = 1'b1
  } res_kind_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_KBD_DATA    = 2'd0,
    REG_KBD_CONTROL = 2'd1,
    REG_DSP_DATA    = 2'd2,
    REG_DSP_CONTROL = 2'd3
  } cfg_reg_e;

  localparam int unsigned AddrW = 16;
  localparam int unsigned ByteW = 8;

  localparam logic [AddrW-1:0] KbdDataReset    = 16'hD010;
  localparam logic [AddrW-1:0] KbdControlReset = 16'hD011;
  localparam logic [AddrW-1:0] DspDataReset    = 16'hD012;
  localparam logic [AddrW-1:0] DspControlReset = 16'hD013;

  localparam logic [ByteW-1:0] CharLineFeed = 8'h0A;
  localparam logic [ByteW-1:0] CharReturn   = 8'h0D;
  localparam logic [ByteW-1:0] StrobeBit    = 8'h80;

  // one queued result
  typedef struct packed {
    res_kind_e        rkind;
    logic [ByteW-1:0] value;
    logic             last;
  } res_t;

  // host key byte to machine code, zero when the key has no mapping
  function automatic logic [ByteW-1:0] key_to_code(input logic [ByteW-1:0] k);
    logic [ByteW-1:0] c;
    if (k <= 8'h08) c = k;
    else if (k == 8'h09) c = '0;
    else if (k == CharLineFeed) c = CharReturn;
    else if (k <= 8'h5F) c = k;
    else if (k == 8'h60) c = '0;
    else if (k <= 8'h7A) c = k - 8'h20;
    else if (k == 8'h7F) c = 8'h5F;
    else c = '0;
    return c;
  endfunction

  // machine code to display character, zero for control codes other than return, which maps to line feed
  function automatic logic [ByteW-1:0] code_to_display(input logic [6:0] c);
    logic [ByteW-1:0] d;
    logic [ByteW-1:0] cw;
    cw = {1'b0, c};
    if (cw == CharReturn) d = CharLineFeed;
    else if (cw < 8'h20) d = '0;
    else if (cw < 8'h60) d = cw;
    else d = cw - 8'h20;
    return d;
  endfunction

endpackage

FILE: rtl/pia_keyboard_display_port_top.sv
// channel       | direction | handshake                   | payload
// --------------+-----------+-----------------------------+-------------------------------------
// s_axis        | in        | s_axis_tvalid_i/tready_o    | tuser kind, tdata addr/wdata/key
// m_axis        | out       | m_axis_tvalid_o/tready_i    | tuser result kind, tdata value, tlast
// cfg           | in        | cfg_we_i (no stall)         | cfg_index_i, cfg_data_i
//
// one input transaction is accepted per cycle while s_axis_tready_o is high; its whole step
// (key service, display service, bus access) is resolved in that cycle into the adapter
// registers; the 0 to 3 results it causes go into a 4-entry output queue drained at one
// per cycle while m_axis_tready_i is high; input is taken while the queue holds at most
// one entry, so with one result per transaction and a ready output the block sustains one
// transaction per cycle, and a three-result step stalls the input until the queue drains
// to one entry. rst_ni clears all adapter state and queue count, presets address registers
module pia_keyboard_display_port_top #(
  parameter int unsigned LINE_COLUMNS = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // address[15:0], write_data[23:16], key_code[31:24]
  input  logic [1:0]  s_axis_tuser_i,   // kind[1:0]
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // value[7:0]
  output logic        m_axis_tuser_o,   // result_kind[0]
  output logic        m_axis_tlast_o,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import pia_kdp_pkg::*;

  localparam int unsigned ColW   = $clog2(LINE_COLUMNS + 1);
  localparam int unsigned QDepth = 4;
  localparam int unsigned CntW   = $clog2(QDepth + 1);
  localparam int unsigned MaxRes = 3;

  // bus address registers
  logic [AddrW-1:0] kda_q, kca_q, dda_q, dca_q;

  // adapter state
  logic [ByteW-1:0] ca_q, ca_d;   // control a
  logic [ByteW-1:0] cb_q, cb_d;   // control b
  logic [ByteW-1:0] pa_q, pa_d;   // port a data
  logic [ByteW-1:0] pb_q, pb_d;   // port b data
  logic [ByteW-1:0] da_q, da_d;   // direction a
  logic [ByteW-1:0] db_q, db_d;   // direction b
  logic             kp_q, kp_d;   // key pending
  logic [ByteW-1:0] pk_q, pk_d;   // pending key byte
  logic [ColW-1:0]  col_q, col_d;

  // output queue, head at entry 0
  res_t            q_q [QDepth];
  res_t            q_d [QDepth];
  logic [CntW-1:0] cnt_q, cnt_d;

  // unpacked input fields
  kind_e            kind;
  logic [AddrW-1:0] addr;
  logic [ByteW-1:0] wdata;
  logic [ByteW-1:0] key;
  logic             in_acc;
  logic             out_acc;

  // step results before compaction
  logic             wrap_v, char_v, read_v;
  logic [ByteW-1:0] read_val;
  logic [ByteW-1:0] code, ch;
  res_t             res [MaxRes];
  logic [1:0]       res_n;

  logic [CntW-1:0]  cnt_pop;
  logic [CntW-1:0]  slot;

  assign kind  = kind_e'(s_axis_tuser_i);
  assign addr  = s_axis_tdata_i[15:0];
  assign wdata = s_axis_tdata_i[23:16];
  assign key   = s_axis_tdata_i[31:24];

  assign s_axis_tready_o = (cnt_q <= CntW'(1));
  assign in_acc  = s_axis_tvalid_i & s_axis_tready_o;
  assign m_axis_tvalid_o = (cnt_q != '0);
  assign out_acc = m_axis_tvalid_o & m_axis_tready_i;

  assign m_axis_tdata_o = q_q[0].value;
  assign m_axis_tuser_o = q_q[0].rkind;
  assign m_axis_tlast_o = q_q[0].last;

  // translations of the held key and of the display byte
  assign code = key_to_code(pk_q);
  assign ch   = code_to_display(pb_q[6:0]);

  // one full adapter step for the accepted transaction
  always_comb begin
    ca_d = ca_q;
    cb_d = cb_q;
    pa_d = pa_q;
    pb_d = pb_q;
    da_d = da_q;
    db_d = db_q;
    kp_d = kp_q;
    pk_d = pk_q;
    col_d = col_q;
    wrap_v = 1'b0;
    char_v = 1'b0;
    read_v = 1'b0;
    read_val = '0;
    if (in_acc) begin
      if (kind == KIND_KEY) begin
        if (!kp_q) begin
          pk_d = key;
          kp_d = 1'b1;
        end
      end else begin
        // keyboard service: latch the key unless the cpu has not read the last one; an unmapped key is dropped
        if (kp_q && !ca_q[7]) begin
          if (code != '0) begin
            pa_d = code | StrobeBit;
            ca_d[7] = 1'b1;
          end
          kp_d = 1'b0;
        end
        // display service with column wrap
        if (pb_q[7]) begin
          pb_d[7] = 1'b0;
          if (ch != '0) begin
            char_v = 1'b1;
            if (ch == CharLineFeed) begin
              col_d = '0;
            end else if (col_q == ColW'(LINE_COLUMNS)) begin
              wrap_v = 1'b1;
              col_d = ColW'(1);
            end else begin
              col_d = col_q + ColW'(1);
            end
          end
        end
        // bus access; control a has priority, then control b, port a, port b
        case (kind)
          KIND_READ: begin
            if (addr == kca_q) begin
              read_v = 1'b1;
              read_val = ca_d;
            end else if (addr == dca_q) begin
              read_v = 1'b1;
              read_val = cb_q;
            end else if (addr == kda_q) begin
              read_v = 1'b1;
              read_val = ca_q[2] ? pa_d : da_q;
              ca_d[7] = 1'b0;   // reading port a acknowledges the key
            end else if (addr == dda_q) begin
              read_v = 1'b1;
              read_val = cb_q[2] ? pb_d : db_q;
            end
          end
          KIND_WRITE: begin
            if (addr == kca_q) begin
              ca_d = {ca_d[7:6], wdata[5:0]};
            end else if (addr == dca_q) begin
              cb_d = {cb_q[7:6], wdata[5:0]};
            end else if (addr == kda_q) begin
              if (ca_q[2]) pa_d = wdata;
              else da_d = wdata;
            end else if (addr == dda_q) begin
              // a port b write always sets bit 7, raising the display strobe only when cb_q[2] selects port b data
              if (cb_q[2]) pb_d = wdata | StrobeBit;
              else db_d = wdata | StrobeBit;
            end
          end
          KIND_IDLE: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  // pack the step results in order: wrap line feed, display character, read byte
  always_comb begin
    for (int i = 0; i < MaxRes; i++) begin
      res[i] = '{rkind: RES_READ, value: '0, last: 1'b0};
    end
    res_n = '0;
    if (wrap_v) begin
      res[res_n] = '{rkind: RES_DISPLAY, value: CharLineFeed, last: 1'b0};
      res_n = res_n + 2'd1;
    end
    if (char_v) begin
      res[res_n] = '{rkind: RES_DISPLAY, value: ch, last: 1'b0};
      res_n = res_n + 2'd1;
    end
    if (read_v) begin
      res[res_n] = '{rkind: RES_READ, value: read_val, last: 1'b0};
      res_n = res_n + 2'd1;
    end
    if (res_n != '0) begin
      res[res_n - 2'd1].last = 1'b1;
    end
  end

  // queue: shift on pop, append new results behind what stays
  always_comb begin
    cnt_pop = cnt_q - CntW'(out_acc);
    for (int i = 0; i < QDepth; i++) begin
      if (out_acc && (i + 1 < QDepth)) q_d[i] = q_q[i + 1];
      else q_d[i] = q_q[i];
    end
    slot = '0;
    for (int i = 0; i < QDepth; i++) begin
      slot = CntW'(i) - cnt_pop;
      if (in_acc && (CntW'(i) >= cnt_pop) && (slot < CntW'(res_n))) begin
        q_d[i] = res[slot[1:0]];
      end
    end
    cnt_d = cnt_pop + (in_acc ? CntW'(res_n) : CntW'(0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kda_q <= KbdDataReset;
      kca_q <= KbdControlReset;
      dda_q <= DspDataReset;
      dca_q <= DspControlReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_KBD_DATA:    kda_q <= cfg_data_i;
        REG_KBD_CONTROL: kca_q <= cfg_data_i;
        REG_DSP_DATA:    dda_q <= cfg_data_i;
        REG_DSP_CONTROL: dca_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ca_q  <= '0;
      cb_q  <= '0;
      pa_q  <= '0;
      pb_q  <= '0;
      da_q  <= '0;
      db_q  <= '0;
      kp_q  <= 1'b0;
      pk_q  <= '0;
      col_q <= '0;
      cnt_q <= '0;
    end else begin
      ca_q  <= ca_d;
      cb_q  <= cb_d;
      pa_q  <= pa_d;
      pb_q  <= pb_d;
      da_q  <= da_d;
      db_q  <= db_d;
      kp_q  <= kp_d;
      pk_q  <= pk_d;
      col_q <= col_d;
      cnt_q <= cnt_d;
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  // queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(QDepth))
    else $error("output queue overflow");

  // a clock transaction with the ready bit clear resolves a pending key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && kind != KIND_KEY && !ca_q[7]) |=> !kp_q)
    else $error("key still pending after a clock transaction");

  // column stays within the line
  assert property (@(posedge clk_i) disable iff (!rst_ni) col_q <= ColW'(LINE_COLUMNS))
    else $error("display column out of range");

  // a lone queued result closes its group
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CntW'(1)) |-> m_axis_tlast_o)
    else $error("final queued result lacks tlast");

  // the display strobe is consumed unless a port b write sets it again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && kind != KIND_KEY && pb_q[7] && !(kind == KIND_WRITE && addr == dda_q))
    |=> !pb_q[7])
    else $error("display strobe not consumed");

endmodule
